/* rtl/multi_queue_message_mailbox_macros.svh */
// Assertion macros shared by the mailbox RTL.
// Define NO_ASSERTIONS to compile every check to nothing.
`ifndef MULTI_QUEUE_MESSAGE_MAILBOX_MACROS_SVH
`define MULTI_QUEUE_MESSAGE_MAILBOX_MACROS_SVH

`ifndef NO_ASSERTIONS
`define MQM_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define MQM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define MQM_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define MQM_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

/* rtl/mqm_pkg.sv */
// Types and constants of the multi-queue message mailbox.
// No dependencies.
`timescale 1ns / 1ps

package mqm_pkg;

   localparam int QID_W = 7;
   localparam int NEW_ID_W = 6;
   localparam int MSG_W = 64;

   typedef enum logic [1:0] {
      MODE_CREATE  = 2'd0,
      MODE_DESTROY = 2'd1,
      MODE_SEND    = 2'd2,
      MODE_RECEIVE = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_INVALID = 2'd1,
      STATUS_BLOCK   = 2'd2
   } status_type;

   typedef struct packed {
      mode_type           mode;
      logic [QID_W-1:0]   queue_id;
      logic [MSG_W-1:0]   message_word;
   } req_type;

   typedef struct packed {
      status_type          status;
      logic [NEW_ID_W-1:0] new_queue_id;
      logic [MSG_W-1:0]    message_out;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_EXEC,
      ST_POP
   } state_type;

   typedef struct packed {
      logic capture;
      logic exec;
      logic pop;
   } cmd_type;

   typedef struct packed {
      logic pop_needed;
   } sts_type;

endpackage

/* rtl/mqm_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module mqm_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/mqm_datapath.sv */
// Mailbox datapath: request register, id counter, queue pointer RAM with
// live bits, message RAM and result register. Uses mqm_pkg and mqm_ram.
`timescale 1ns / 1ps
`include "multi_queue_message_mailbox_macros.svh"

module mqm_datapath #(
   parameter int NUM_QUEUES = 64,
   parameter int QUEUE_DEPTH = 16
) (
   input  logic            clock,
   input  logic            reset,
   input  mqm_pkg::req_type req_payload,
   input  mqm_pkg::cmd_type cmd,
   output mqm_pkg::sts_type sts,
   output logic            rsp_strobe,
   output mqm_pkg::rsp_type rsp_payload
);

   import mqm_pkg::*;

   localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
   localparam int NW = $clog2(NUM_QUEUES + 1);
   localparam int PW = $clog2(QUEUE_DEPTH);
   localparam int FW = $clog2(QUEUE_DEPTH + 1);
   localparam int MW = 1 + 2 * PW + FW;
   localparam int META_DEPTH = 2 ** QW;
   localparam int STORE_DEPTH = 2 ** (QW + PW);

   req_type           req_ff;
   logic [NW-1:0]     next_id_ff;
   logic [NW-1:0]     next_id_in;
   rsp_type           rsp_ff;
   rsp_type           rsp_in;
   logic              rsp_strobe_ff;
   logic              rsp_strobe_in;

   logic [QW-1:0]     q_idx;
   logic [QW-1:0]     new_idx;
   logic              usable;
   logic              can_create;

   logic [MW-1:0]     meta_rd;
   logic              q_live;
   logic [PW-1:0]     head;
   logic [PW-1:0]     tail;
   logic [FW-1:0]     fill;
   logic              meta_we;
   logic [QW-1:0]     meta_waddr;
   logic [MW-1:0]     meta_wdata;

   logic              store_we;
   logic [MSG_W-1:0]  store_rd;

   status_type          exec_status;
   logic [NEW_ID_W-1:0] exec_new_id;
   logic                pop_needed;

   function automatic logic [PW-1:0] advance(input logic [PW-1:0] p);
      logic [PW-1:0] r;
      if (p == PW'(QUEUE_DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + PW'(1);
      end
      return r;
   endfunction

   assign q_idx = req_ff.queue_id[QW-1:0];
   assign new_idx = next_id_ff[QW-1:0];
   assign usable = (req_ff.queue_id < QID_W'(next_id_ff)) && q_live;
   assign can_create = next_id_ff < NW'(NUM_QUEUES);
   assign {q_live, head, tail, fill} = meta_rd;

   always_comb begin
      exec_status = STATUS_OK;
      exec_new_id = '0;
      meta_we = 1'b0;
      meta_waddr = q_idx;
      meta_wdata = meta_rd;
      store_we = 1'b0;
      next_id_in = next_id_ff;
      pop_needed = 1'b0;
      if (req_ff.mode == MODE_CREATE) begin
         if (can_create) begin
            meta_we = cmd.exec;
            meta_waddr = new_idx;
            meta_wdata = {1'b1, {(MW - 1){1'b0}}};
            exec_new_id = NEW_ID_W'(next_id_ff);
            if (cmd.exec) begin
               next_id_in = next_id_ff + NW'(1);
            end
         end else begin
            exec_status = STATUS_INVALID;
         end
      end else if (!usable) begin
         exec_status = STATUS_INVALID;
      end else begin
         case (req_ff.mode)
            MODE_DESTROY: begin
               meta_we = cmd.exec;
               meta_wdata = {1'b0, head, tail, fill};
            end
            MODE_SEND: begin
               if (fill == FW'(QUEUE_DEPTH)) begin
                  exec_status = STATUS_BLOCK;
               end else begin
                  store_we = cmd.exec;
                  meta_we = cmd.exec;
                  meta_wdata = {1'b1, head, advance(tail), fill + FW'(1)};
               end
            end
            default: begin
               if (fill == '0) begin
                  exec_status = STATUS_BLOCK;
               end else begin
                  pop_needed = 1'b1;
                  meta_we = cmd.exec;
                  meta_wdata = {1'b1, advance(head), tail, fill - FW'(1)};
               end
            end
         endcase
      end
   end

   assign sts.pop_needed = pop_needed;

   always_comb begin
      rsp_in = rsp_ff;
      rsp_strobe_in = 1'b0;
      if (cmd.pop) begin
         rsp_in.status = STATUS_OK;
         rsp_in.new_queue_id = '0;
         rsp_in.message_out = store_rd;
         rsp_strobe_in = 1'b1;
      end else if (cmd.exec && !pop_needed) begin
         rsp_in.status = exec_status;
         rsp_in.new_queue_id = exec_new_id;
         rsp_in.message_out = '0;
         rsp_strobe_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_payload;
      end
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         next_id_ff <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         next_id_ff <= next_id_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   mqm_ram #(
      .WIDTH (MW),
      .DEPTH (META_DEPTH)
   ) u_meta_ram (
      .clock   (clock),
      .wr_en   (meta_we),
      .wr_addr (meta_waddr),
      .wr_data (meta_wdata),
      .rd_addr (q_idx),
      .rd_data (meta_rd)
   );

   mqm_ram #(
      .WIDTH (MSG_W),
      .DEPTH (STORE_DEPTH)
   ) u_store_ram (
      .clock   (clock),
      .wr_en   (store_we),
      .wr_addr ({q_idx, tail}),
      .wr_data (req_ff.message_word),
      .rd_addr ({q_idx, head}),
      .rd_data (store_rd)
   );

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_payload = rsp_ff;

   `MQM_ASSERT_NEXT(a_strobe_single, clock, reset, rsp_strobe_ff, !rsp_strobe_ff,
      "result strobe held for two cycles")
   `MQM_ASSERT_IMP(a_error_zero, clock, reset,
      rsp_strobe_ff && (rsp_ff.status != STATUS_OK),
      (rsp_ff.message_out == '0) && (rsp_ff.new_queue_id == '0),
      "failed transaction carries nonzero fields")
   `MQM_ASSERT_IMP(a_id_bound, clock, reset, 1'b1, next_id_ff <= NW'(NUM_QUEUES),
      "id counter ran past queue count")

endmodule

/* rtl/mqm_controller.sv */
// Mailbox sequencer: steps each transaction through pointer read,
// execute and optional message pop. Uses mqm_pkg.
`timescale 1ns / 1ps
`include "multi_queue_message_mailbox_macros.svh"

module mqm_controller (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  mqm_pkg::sts_type sts,
   output mqm_pkg::cmd_type cmd
);

   import mqm_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      busy = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.capture = 1'b1;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            state_in = sts.pop_needed ? ST_POP : ST_IDLE;
         end
         ST_POP: begin
            cmd.pop = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   `MQM_ASSERT_IMP(a_pop_after_exec, clock, reset, state_ff == ST_POP,
      $past(state_ff) == ST_EXEC, "pop step without execute step")

endmodule

/* rtl/multi_queue_message_mailbox.sv */
// Multi-queue message mailbox: up to NUM_QUEUES circular FIFOs of 64-bit
// messages with create, destroy, send and receive commands.
//
// Request channel: drive req_payload and raise start; the transaction is
// taken at the edge where start is high and busy is low.
// Result channel: rsp_strobe is high for one cycle with rsp_payload valid;
// there is no backpressure, so the result must be taken in that cycle.
// The result strobe is registered and rises after the pointer read and execute
// steps, and for a receive that pops a message after the pop step as well. busy
// stays high from acceptance until the sequencer is back in idle, so a new
// transaction can be taken only once the last one is through; the pointer RAM
// read and the message RAM read, each with a registered output, call for these steps.
// Reset clears the sequencer, the id counter and the result strobe. The
// pointer RAM also holds each queue's live bit and needs no clearing: only
// ids below the id counter are looked up, and each was written on create.
// Messages are read only after being sent.
`timescale 1ns / 1ps

module multi_queue_message_mailbox #(
   parameter int NUM_QUEUES = 64,
   parameter int QUEUE_DEPTH = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  mqm_pkg::req_type req_payload,
   output logic             rsp_strobe,
   output mqm_pkg::rsp_type rsp_payload
);

   import mqm_pkg::*;

   cmd_type cmd;
   sts_type sts;

   mqm_controller u_controller (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .cmd   (cmd)
   );

   mqm_datapath #(
      .NUM_QUEUES  (NUM_QUEUES),
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload)
   );

endmodule

/* verif/tb_multi_queue_message_mailbox.sv */
`timescale 1ns / 1ps

// Testbench for multi_queue_message_mailbox: directed and random create, destroy,
// send and receive transactions, each reply checked against an in-bench mailbox model.
// Depends on mqm_pkg and the multi_queue_message_mailbox RTL.
module tb_multi_queue_message_mailbox;
   import mqm_pkg::*;

   localparam int NUM_QUEUES = 64;
   localparam int QUEUE_DEPTH = 16;
   localparam int RANDOM_COUNT = 1950;
   localparam int PHASE_LEN = 150;
   localparam int QUIET_LIMIT = 2000;
   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   typedef struct {
      req_type req;
      bit      drain_first;
   } queued_req_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   req_type req_payload = '0;
   logic    busy;
   logic    rsp_strobe;
   rsp_type rsp_payload;

   queued_req_type request_queue[$];
   rsp_type        pending_replies[$];

   bit               qlive[NUM_QUEUES];
   logic [PTR_W-1:0] qhead[NUM_QUEUES];
   logic [PTR_W-1:0] qtail[NUM_QUEUES];
   logic [PTR_W:0]   qfill[NUM_QUEUES];
   logic [MSG_W-1:0] msg_store[NUM_QUEUES*QUEUE_DEPTH];
   int               model_next_id = 0;

   bit req_taken = 1'b0;
   bit timed_out = 1'b0;
   int gap_left = 0;
   int calm_left = 0;
   int quiet_cycles = 0;
   int failures = 0;

   multi_queue_message_mailbox #(
      .NUM_QUEUES(NUM_QUEUES),
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_payload(req_payload),
      .rsp_strobe(rsp_strobe),
      .rsp_payload(rsp_payload)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic rsp_type serve_request(req_type r);
      rsp_type reply;
      int q;
      reply.status = STATUS_OK;
      reply.new_queue_id = '0;
      reply.message_out = '0;
      q = r.queue_id;
      if (r.mode == MODE_CREATE) begin
         if (model_next_id >= NUM_QUEUES) begin
            reply.status = STATUS_INVALID;
         end else begin
            qlive[model_next_id] = 1'b1;
            qhead[model_next_id] = '0;
            qtail[model_next_id] = '0;
            qfill[model_next_id] = '0;
            reply.new_queue_id = NEW_ID_W'(model_next_id);
            model_next_id++;
         end
      end else if (q >= NUM_QUEUES || !qlive[q]) begin
         reply.status = STATUS_INVALID;
      end else if (r.mode == MODE_DESTROY) begin
         qlive[q] = 1'b0;
      end else if (r.mode == MODE_SEND) begin
         if (qfill[q] >= QUEUE_DEPTH) begin
            reply.status = STATUS_BLOCK;
         end else begin
            msg_store[q*QUEUE_DEPTH + qtail[q]] = r.message_word;
            qtail[q] = (qtail[q] == QUEUE_DEPTH-1) ? '0 : qtail[q] + 1'b1;
            qfill[q] = qfill[q] + 1'b1;
         end
      end else begin
         if (qfill[q] == 0) begin
            reply.status = STATUS_BLOCK;
         end else begin
            reply.message_out = msg_store[q*QUEUE_DEPTH + qhead[q]];
            qhead[q] = (qhead[q] == QUEUE_DEPTH-1) ? '0 : qhead[q] + 1'b1;
            qfill[q] = qfill[q] - 1'b1;
         end
      end
      return reply;
   endfunction

   task automatic add_req(mode_type mode, int qid, logic [MSG_W-1:0] word, bit drain);
      queued_req_type item;
      item.req.mode = mode;
      item.req.queue_id = QID_W'(qid);
      item.req.message_word = word;
      item.drain_first = drain;
      request_queue.push_back(item);
   endtask

   always @(negedge clock) begin : driver
      int next_gap;
      int roll;
      if (reset) begin
         start <= 1'b0;
      end else if (start && !req_taken) begin
         // hold the transaction until taken
      end else if (gap_left != 0) begin
         start <= 1'b0;
         gap_left <= gap_left - 1;
      end else if (request_queue.size() != 0
                   && !(request_queue[0].drain_first && pending_replies.size() != 0)) begin
         roll = $urandom_range(0, 99);
         if (calm_left != 0) begin
            next_gap = 0;
            calm_left <= calm_left - 1;
         end else if (roll < 3) begin
            next_gap = 0;
            calm_left <= $urandom_range(20, 80);
         end else if (roll < 50) begin
            next_gap = 0;
         end else if (roll < 85) begin
            next_gap = $urandom_range(1, 3);
         end else if (roll < 97) begin
            next_gap = $urandom_range(4, 12);
         end else begin
            next_gap = $urandom_range(20, 60);
         end
         req_payload <= request_queue[0].req;
         start <= 1'b1;
         gap_left <= next_gap;
         void'(request_queue.pop_front());
      end else begin
         start <= 1'b0;
      end
   end

   always @(posedge clock) begin : monitor
      rsp_type want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         if (rsp_strobe === 1'b1) begin
            if (pending_replies.size() == 0) begin
               failures++;
               $display("%0t: unexpected reply, expected none, got status %0d id %0d msg %h",
                        $time, rsp_payload.status, rsp_payload.new_queue_id,
                        rsp_payload.message_out);
            end else begin
               want = pending_replies.pop_front();
               if (rsp_payload.status !== want.status) begin
                  failures++;
                  $display("%0t: status mismatch, expected %0d, got %0d",
                           $time, want.status, rsp_payload.status);
               end
               if (rsp_payload.new_queue_id !== want.new_queue_id) begin
                  failures++;
                  $display("%0t: new_queue_id mismatch, expected %0d, got %0d",
                           $time, want.new_queue_id, rsp_payload.new_queue_id);
               end
               if (rsp_payload.message_out !== want.message_out) begin
                  failures++;
                  $display("%0t: message_out mismatch, expected %h, got %h",
                           $time, want.message_out, rsp_payload.message_out);
               end
            end
         end
         if (start && !busy) begin
            pending_replies.push_back(serve_request(req_payload));
         end
         req_taken <= start && !busy;
         if (rsp_strobe === 1'b1 || (start && !busy)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles == QUIET_LIMIT && !timed_out) begin
            timed_out <= 1'b1;
            $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   initial begin : stimulus
      int live_ids[$];
      int gen_next_id;
      int send_pct;
      int pick;
      int idx;
      bit drain;

      // dead queue, invalid ids, create ignoring queue_id, empty receive
      add_req(MODE_RECEIVE, 0, '0, 1'b0);
      add_req(MODE_SEND, 127, '1, 1'b0);
      add_req(MODE_DESTROY, NUM_QUEUES, '0, 1'b0);
      add_req(MODE_CREATE, 127, '1, 1'b0);
      add_req(MODE_RECEIVE, 0, '1, 1'b0);
      add_req(MODE_SEND, 0, '1, 1'b0);
      add_req(MODE_RECEIVE, 0, '0, 1'b0);
      // fill to depth, overflow, then kill the queue
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         add_req(MODE_SEND, 0, (i == 0) ? '0 : {$urandom, $urandom}, 1'b0);
      end
      add_req(MODE_SEND, 0, {$urandom, $urandom}, 1'b0);
      add_req(MODE_DESTROY, 0, '0, 1'b0);
      add_req(MODE_SEND, 0, '1, 1'b0);
      gen_next_id = 1;
      send_pct = 50;

      for (int n = 0; n < RANDOM_COUNT; n++) begin
         drain = (n % PHASE_LEN == 0);
         if (drain) begin
            send_pct = $urandom_range(25, 85);
         end
         pick = $urandom_range(0, 99);
         if (pick < 3 || (pick < 88 && live_ids.size() == 0)) begin
            add_req(MODE_CREATE, $urandom_range(0, 127), {$urandom, $urandom}, drain);
            if (gen_next_id < NUM_QUEUES) begin
               live_ids.push_back(gen_next_id);
            end
            gen_next_id++;
         end else if (pick < 5 && live_ids.size() > 2) begin
            idx = $urandom_range(0, live_ids.size() - 1);
            add_req(MODE_DESTROY, live_ids[idx], {$urandom, $urandom}, drain);
            live_ids.delete(idx);
         end else if (pick < 88) begin
            idx = ($urandom_range(0, 99) < 60) ? live_ids.size() - 1
                                               : $urandom_range(0, live_ids.size() - 1);
            add_req(($urandom_range(0, 99) < send_pct) ? MODE_SEND : MODE_RECEIVE,
                    live_ids[idx], {$urandom, $urandom}, drain);
         end else begin
            add_req(mode_type'($urandom_range(1, 3)), $urandom_range(0, 127),
                    {$urandom, $urandom}, drain);
         end
      end
      // exhaust the id table
      while (gen_next_id <= NUM_QUEUES) begin
         add_req(MODE_CREATE, $urandom_range(0, 127), {$urandom, $urandom}, 1'b0);
         gen_next_id++;
      end

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (!(timed_out || (request_queue.size() == 0 && !start
                             && pending_replies.size() == 0))) begin
         @(posedge clock);
      end
      if (!timed_out) begin
         repeat (10) @(posedge clock);
      end
      if (timed_out || failures != 0 || pending_replies.size() != 0) begin
         $display("multi_queue_message_mailbox verification failed");
      end else begin
         $display("multi_queue_message_mailbox verification clean");
      end
      $finish;
   end

endmodule

/* files.f */
+incdir+rtl
rtl/mqm_pkg.sv
rtl/mqm_ram.sv
rtl/mqm_datapath.sv
rtl/mqm_controller.sv
rtl/multi_queue_message_mailbox.sv
verif/tb_multi_queue_message_mailbox.sv
